// ===== hw/rtl/icr_pkg.sv =====
`default_nettype none

package icr_pkg;

  localparam logic [63:0] CAP62      = 64'h4000_0000_0000_0000;
  localparam logic [30:0] ONE30      = 31'h4000_0000;
  localparam int          DIV_STAGES = 31;

  typedef enum logic [1:0] {
    ST_APPLIED     = 2'd0,
    ST_ZERO_NORMAL = 2'd1,
    ST_SEPARATING  = 2'd2,
    ST_NO_MASS     = 2'd3
  } status_t;

  // Contact geometry and flags that travel with an item down the pipeline.
  typedef struct packed {
    logic [2:0][17:0] n;
    logic [30:0]      pen;
    logic [1:0]       kin;
    logic             ma_zero;
    logic             mb_zero;
    status_t          status;
  } geo_t;

  typedef struct packed {
    geo_t        g;
    logic [62:0] w;
  } contact_t;

  typedef struct packed {
    contact_t    c;
    logic [62:0] num;
    logic [32:0] den;
  } front_t;

  typedef struct packed {
    contact_t    c;
    logic [30:0] q;
  } divd_t;

  // Finishes a split magnitude multiply: ph and pl are the products of the high
  // bits and the low 32 bits of the wide operand. Rounds half up after a right
  // shift by s (1..32) and caps the result at 2^62.
  function automatic logic [62:0] umul_fin(input logic [63:0] ph, input logic [63:0] pl,
                                           input int unsigned s);
    logic [63:0] lim;
    logic [63:0] high;
    logic [63:0] low;
    logic [63:0] sum;
    lim = CAP62 >> (32 - s);
    low = (pl + (64'd1 << (s - 1))) >> s;
    if (ph > lim) begin
      high = CAP62;
    end else begin
      high = ph << (32 - s);
    end
    sum = high + low;
    if (sum > CAP62) begin
      return CAP62[62:0];
    end
    return sum[62:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [62:0] mag, input logic neg);
    if (neg) begin
      if (mag >= 63'h8000_0000) begin
        return 32'h8000_0000;
      end
      return 32'd0 - mag[31:0];
    end
    if (mag > 63'h7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/icr_front.sv =====
`default_nettype none

module icr_front import icr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] rel_vel_x,
  input  wire logic signed [31:0] rel_vel_y,
  input  wire logic signed [31:0] rel_vel_z,
  input  wire logic signed [17:0] normal_x,
  input  wire logic signed [17:0] normal_y,
  input  wire logic signed [17:0] normal_z,
  input  wire logic        [30:0] penetration,
  input  wire logic        [31:0] mass_a,
  input  wire logic        [31:0] mass_b,
  input  wire logic        [17:0] bounce_a,
  input  wire logic        [17:0] bounce_b,
  input  wire logic        [1:0]  kinematic_mask,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output front_t                  out_item
);

  localparam logic [51:0] HALF_VN = 52'd1 << (FRAC_BITS - 1);
  localparam logic [31:0] K_BASE  = 32'd1 << (FRAC_BITS + 1);

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;

  // Stage 1: the three dot product terms.
  logic signed [49:0] prod_nxt [3];
  logic signed [49:0] s1_prod_r [3];
  logic [2:0][17:0]   s1_n_r;
  logic [30:0]        s1_pen_r;
  logic [31:0]        s1_ma_r, s1_mb_r;
  logic [17:0]        s1_ba_r, s1_bb_r;
  logic [1:0]         s1_kin_r;

  // Stage 2: normal speed.
  logic signed [51:0] vn_nxt;
  logic signed [51:0] s2_vn_r;
  logic               s2_nzero_r;
  logic [2:0][17:0]   s2_n_r;
  logic [30:0]        s2_pen_r;
  logic [31:0]        s2_ma_r, s2_mb_r;
  logic [17:0]        s2_ba_r, s2_bb_r;
  logic [1:0]         s2_kin_r;

  // Stage 3: status, rounded speed, impulse scale and divider operands.
  status_t     status_nxt;
  logic [51:0] vh_nxt;
  logic [32:0] msum_nxt;
  geo_t        s3_g_r;
  logic [62:0] s3_spd_r;
  logic [31:0] s3_k_r;
  logic [62:0] s3_num_r;
  logic [32:0] s3_den_r;

  // Stage 4: partial products of speed times scale.
  logic [63:0] ph_nxt, pl_nxt;
  logic [63:0] s4_ph_r, s4_pl_r;
  geo_t        s4_g_r;
  logic [62:0] s4_num_r;
  logic [32:0] s4_den_r;

  front_t s5_item_r;

  assign rdy5     = !s5_v_r || out_ready;
  assign rdy4     = !s4_v_r || rdy5;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  assign prod_nxt[0] = rel_vel_x * normal_x;
  assign prod_nxt[1] = rel_vel_y * normal_y;
  assign prod_nxt[2] = rel_vel_z * normal_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_prod_r <= prod_nxt;
      s1_n_r    <= {normal_z, normal_y, normal_x};
      s1_pen_r  <= penetration;
      s1_ma_r   <= mass_a;
      s1_mb_r   <= mass_b;
      s1_ba_r   <= bounce_a;
      s1_bb_r   <= bounce_b;
      s1_kin_r  <= kinematic_mask;
    end
  end

  assign vn_nxt = 52'(s1_prod_r[0]) + 52'(s1_prod_r[1]) + 52'(s1_prod_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_vn_r    <= vn_nxt;
      s2_nzero_r <= (s1_n_r == '0);
      s2_n_r     <= s1_n_r;
      s2_pen_r   <= s1_pen_r;
      s2_ma_r    <= s1_ma_r;
      s2_mb_r    <= s1_mb_r;
      s2_ba_r    <= s1_ba_r;
      s2_bb_r    <= s1_bb_r;
      s2_kin_r   <= s1_kin_r;
    end
  end

  always_comb begin
    priority if (s2_nzero_r) begin
      status_nxt = ST_ZERO_NORMAL;
    end else if (s2_vn_r[51]) begin
      status_nxt = ST_SEPARATING;
    end else if (s2_ma_r == '0 && s2_mb_r == '0) begin
      status_nxt = ST_NO_MASS;
    end else begin
      status_nxt = ST_APPLIED;
    end
  end

  // The rounded speed is only used when the normal speed is not negative.
  assign vh_nxt   = s2_vn_r + HALF_VN;
  assign msum_nxt = 33'(s2_ma_r) + 33'(s2_mb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_g_r.n       <= s2_n_r;
      s3_g_r.pen     <= s2_pen_r;
      s3_g_r.kin     <= s2_kin_r;
      s3_g_r.ma_zero <= (s2_ma_r == '0);
      s3_g_r.mb_zero <= (s2_mb_r == '0);
      s3_g_r.status  <= status_nxt;
      s3_spd_r       <= 63'(vh_nxt[51:FRAC_BITS]);
      s3_k_r         <= K_BASE + 32'(s2_ba_r) + 32'(s2_bb_r);
      s3_num_r       <= 63'({s2_mb_r, 30'd0}) + 63'(msum_nxt[32:1]);
      s3_den_r       <= msum_nxt;
    end
  end

  assign ph_nxt = s3_spd_r[62:32] * s3_k_r;
  assign pl_nxt = s3_spd_r[31:0] * s3_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (rdy4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      s4_ph_r  <= ph_nxt;
      s4_pl_r  <= pl_nxt;
      s4_g_r   <= s3_g_r;
      s4_num_r <= s3_num_r;
      s4_den_r <= s3_den_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (rdy5) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && s4_v_r) begin
      s5_item_r.c.g <= s4_g_r;
      s5_item_r.c.w <= umul_fin(s4_ph_r, s4_pl_r, FRAC_BITS + 1);
      s5_item_r.num <= s4_num_r;
      s5_item_r.den <= s4_den_r;
    end
  end

  assign out_valid = s5_v_r;
  assign out_item  = s5_item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/icr_div.sv =====
`default_nettype none

module icr_div import icr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire front_t in_item,
  output logic        out_valid,
  input  wire logic   out_ready,
  output divd_t       out_item
);

  // One quotient bit per stage. The shift field starts as the low numerator
  // bits and fills with quotient bits from the right.
  typedef struct packed {
    contact_t    c;
    logic [32:0] den;
    logic [32:0] rem;
    logic [30:0] sh;
  } dstage_t;

  dstage_t               src_s [DIV_STAGES];
  dstage_t               nxt_s [DIV_STAGES];
  dstage_t               st_r  [DIV_STAGES];
  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES-1:0] rdy;
  logic [DIV_STAGES-1:0] src_v;

  assign src_s[0].c   = in_item.c;
  assign src_s[0].den = in_item.den;
  assign src_s[0].rem = {1'b0, in_item.num[62:31]};
  assign src_s[0].sh  = in_item.num[30:0];
  assign src_v[0]     = in_valid;
  assign in_ready     = rdy[0];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [33:0] t;
    logic        ge;

    if (j > 0) begin : g_link
      assign src_s[j] = st_r[j-1];
      assign src_v[j] = v_r[j-1];
    end

    if (j == DIV_STAGES - 1) begin : g_last
      assign rdy[j] = !v_r[j] || out_ready;
    end else begin : g_mid
      assign rdy[j] = !v_r[j] || rdy[j+1];
    end

    assign t  = {src_s[j].rem, src_s[j].sh[30]};
    assign ge = (t >= {1'b0, src_s[j].den});

    always_comb begin
      nxt_s[j]     = src_s[j];
      nxt_s[j].rem = ge ? 33'(t - {1'b0, src_s[j].den}) : t[32:0];
      nxt_s[j].sh  = {src_s[j].sh[29:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= src_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && src_v[j]) begin
        st_r[j] <= nxt_s[j];
      end
    end
  end

  assign out_valid  = v_r[DIV_STAGES-1];
  assign out_item.c = st_r[DIV_STAGES-1].c;
  assign out_item.q = st_r[DIV_STAGES-1].sh;

endmodule

`default_nettype wire

// ===== hw/rtl/icr_body.sv =====
`default_nettype none

module icr_body import icr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire divd_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       out_which_body,
  output logic [31:0] out_dvel_x,
  output logic [31:0] out_dvel_y,
  output logic [31:0] out_dvel_z,
  output logic [31:0] out_dpos_x,
  output logic [31:0] out_dpos_y,
  output logic [31:0] out_dpos_z,
  output logic [1:0]  out_status
);

  typedef struct packed {
    logic             which;
    status_t          status;
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][17:0] an;
  } beat_t;

  logic rdy1, rdy2, rdy3, rdy4;
  logic e_v_r, e_ph_r;
  logic b1_v_r, b2_v_r, b3_v_r, b4_v_r;
  divd_t e_item_r;

  logic [30:0] fa_nxt, f_nxt;
  beat_t       beat_nxt;

  beat_t       b1_beat_r;
  logic [63:0] b1_gh_r, b1_gl_r, b1_pp_r;

  beat_t       b2_beat_r;
  logic [62:0] b2_g_r, b2_p_r;

  beat_t       b3_beat_r;
  logic [63:0] b3_gh_r [3];
  logic [63:0] b3_gl_r [3];
  logic [63:0] b3_pl_r [3];

  logic [31:0] dvel_nxt [3];
  logic [31:0] dpos_nxt [3];
  logic [31:0] dvel_r   [3];
  logic [31:0] dpos_r   [3];
  logic        which_r;
  status_t     status_r;

  assign rdy4 = !b4_v_r || out_ready;
  assign rdy3 = !b3_v_r || rdy4;
  assign rdy2 = !b2_v_r || rdy3;
  assign rdy1 = !b1_v_r || rdy2;

  // The contact is held here until both its results are taken: body a goes out first, then body b.
  assign in_ready = !e_v_r || (e_ph_r && rdy1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r  <= 1'b0;
      e_ph_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      e_v_r  <= 1'b1;
      e_ph_r <= 1'b0;
    end else if (e_v_r && rdy1) begin
      if (!e_ph_r) begin
        e_ph_r <= 1'b1;
      end else begin
        e_v_r  <= 1'b0;
        e_ph_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      e_item_r <= in_item;
    end
  end

  always_comb begin
    priority if (e_item_r.c.g.ma_zero) begin
      fa_nxt = '0;
    end else if (e_item_r.c.g.mb_zero) begin
      fa_nxt = ONE30;
    end else begin
      fa_nxt = e_item_r.q;
    end
    f_nxt = e_ph_r ? (ONE30 - fa_nxt) : fa_nxt;

    beat_nxt.which  = e_ph_r;
    beat_nxt.status = e_item_r.c.g.status;
    beat_nxt.zero   = (e_item_r.c.g.status != ST_APPLIED) || e_item_r.c.g.kin[e_ph_r];
    for (int i = 0; i < 3; i++) begin
      // Body a moves against the normal, body b along it.
      beat_nxt.neg[i] = e_item_r.c.g.n[i][17] ^ !e_ph_r;
      beat_nxt.an[i]  = e_item_r.c.g.n[i][17] ? (18'd0 - e_item_r.c.g.n[i])
                                              : e_item_r.c.g.n[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (rdy1) begin
      b1_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && e_v_r) begin
      b1_beat_r <= beat_nxt;
      b1_gh_r   <= e_item_r.c.w[62:32] * f_nxt;
      b1_gl_r   <= e_item_r.c.w[31:0] * f_nxt;
      b1_pp_r   <= e_item_r.c.g.pen * f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (rdy2) begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && b1_v_r) begin
      b2_beat_r <= b1_beat_r;
      b2_g_r    <= umul_fin(b1_gh_r, b1_gl_r, 30);
      b2_p_r    <= umul_fin(64'd0, b1_pp_r, 30);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_v_r <= 1'b0;
    end else if (rdy3) begin
      b3_v_r <= b2_v_r;
    end
  end

  // The position scale never exceeds the penetration, so its low word suffices.
  always_ff @(posedge clk) begin
    if (rdy3 && b2_v_r) begin
      b3_beat_r <= b2_beat_r;
      for (int i = 0; i < 3; i++) begin
        b3_gh_r[i] <= b2_g_r[62:32] * b2_beat_r.an[i];
        b3_gl_r[i] <= b2_g_r[31:0] * b2_beat_r.an[i];
        b3_pl_r[i] <= b2_p_r[31:0] * b2_beat_r.an[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b3_beat_r.zero) begin
        dvel_nxt[i] = '0;
        dpos_nxt[i] = '0;
      end else begin
        dvel_nxt[i] = sat32(umul_fin(b3_gh_r[i], b3_gl_r[i], FRAC_BITS),
                            b3_beat_r.neg[i]);
        dpos_nxt[i] = sat32(umul_fin(64'd0, b3_pl_r[i], FRAC_BITS), b3_beat_r.neg[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b4_v_r <= 1'b0;
    end else if (rdy4) begin
      b4_v_r <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && b3_v_r) begin
      which_r  <= b3_beat_r.which;
      status_r <= b3_beat_r.status;
      dvel_r   <= dvel_nxt;
      dpos_r   <= dpos_nxt;
    end
  end

  assign out_valid      = b4_v_r;
  assign out_which_body = which_r;
  assign out_status     = status_r;
  assign out_dvel_x     = dvel_r[0];
  assign out_dvel_y     = dvel_r[1];
  assign out_dvel_z     = dvel_r[2];
  assign out_dpos_x     = dpos_r[0];
  assign out_dpos_y     = dpos_r[1];
  assign out_dpos_z     = dpos_r[2];

endmodule

`default_nettype wire

// ===== hw/rtl/impulse_collision_response.sv =====
// Impulse collision response: each accepted contact (relative velocity, unit
// normal, penetration, masses, restitutions, kinematic flags) yields two result
// transactions, body a then body b, each with a velocity change, a position
// correction and a status; the deltas are not applied to any stored state. All
// values are fixed point with FRAC_BITS fraction bits, and the outputs saturate
// to the signed 32-bit range. In steady state the block accepts contacts at half
// the result rate, since both results of a contact leave through the one result
// port. A contact passes through 41 register stages in all: five front stages,
// 31 stages of the mass-ratio divider that makes one quotient bit per stage, and
// five per-body stages. Stalls on the result side back up through the pipeline
// without losing or repeating any transaction.
`default_nettype none

module impulse_collision_response import icr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_rel_vel_x,
  input  wire logic signed [31:0] in_rel_vel_y,
  input  wire logic signed [31:0] in_rel_vel_z,
  input  wire logic signed [17:0] in_normal_x,
  input  wire logic signed [17:0] in_normal_y,
  input  wire logic signed [17:0] in_normal_z,
  input  wire logic        [30:0] in_penetration,
  input  wire logic        [31:0] in_mass_a,
  input  wire logic        [31:0] in_mass_b,
  input  wire logic        [17:0] in_bounce_a,
  input  wire logic        [17:0] in_bounce_b,
  input  wire logic        [1:0]  in_kinematic_mask,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_which_body,
  output logic                    out_last,
  output logic signed [31:0]      out_dvel_x,
  output logic signed [31:0]      out_dvel_y,
  output logic signed [31:0]      out_dvel_z,
  output logic signed [31:0]      out_dpos_x,
  output logic signed [31:0]      out_dpos_y,
  output logic signed [31:0]      out_dpos_z,
  output logic        [1:0]       out_status
);

  logic   fr_valid, fr_ready;
  front_t fr_item;
  logic   dv_valid, dv_ready;
  divd_t  dv_item;
  logic   which;

  icr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rel_vel_x      (in_rel_vel_x),
    .rel_vel_y      (in_rel_vel_y),
    .rel_vel_z      (in_rel_vel_z),
    .normal_x       (in_normal_x),
    .normal_y       (in_normal_y),
    .normal_z       (in_normal_z),
    .penetration    (in_penetration),
    .mass_a         (in_mass_a),
    .mass_b         (in_mass_b),
    .bounce_a       (in_bounce_a),
    .bounce_b       (in_bounce_b),
    .kinematic_mask (in_kinematic_mask),
    .out_valid      (fr_valid),
    .out_ready      (fr_ready),
    .out_item       (fr_item)
  );

  icr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_item  (dv_item)
  );

  icr_body #(.FRAC_BITS(FRAC_BITS)) u_body (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (dv_valid),
    .in_ready       (dv_ready),
    .in_item        (dv_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_which_body (which),
    .out_dvel_x     (out_dvel_x),
    .out_dvel_y     (out_dvel_y),
    .out_dvel_z     (out_dvel_z),
    .out_dpos_x     (out_dpos_x),
    .out_dpos_y     (out_dpos_y),
    .out_dpos_z     (out_dpos_z),
    .out_status     (out_status)
  );

  assign out_which_body = which;
  assign out_last       = which;

endmodule

`default_nettype wire

// ===== hw/rtl/icr_checker.sv =====
`default_nettype none

module icr_props import icr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_which_body,
  input wire logic        out_last,
  input wire logic [31:0] out_dvel_x,
  input wire logic [31:0] out_dvel_y,
  input wire logic [31:0] out_dvel_z,
  input wire logic [31:0] out_dpos_x,
  input wire logic [31:0] out_dpos_y,
  input wire logic [31:0] out_dpos_z,
  input wire logic [1:0]  out_status
);

  // The last flag is set exactly on the body b result, the second of a contact.
  a_last_is_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_which_body))
    else $error("last flag does not match body select");

  // A rejected contact carries no deltas.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_APPLIED) |->
      (out_dvel_x == '0) && (out_dvel_y == '0) && (out_dvel_z == '0) &&
      (out_dpos_x == '0) && (out_dpos_y == '0) && (out_dpos_z == '0))
    else $error("nonzero delta on a rejected contact");

  // After a body a transaction, the next result shown can only be body b.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !(out_valid && !out_last))
    else $error("body a result not followed by body b result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_which_body) &&
      $stable(out_dvel_x) && $stable(out_dpos_x) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind impulse_collision_response icr_props u_icr_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_which_body (out_which_body),
  .out_last       (out_last),
  .out_dvel_x     (out_dvel_x),
  .out_dvel_y     (out_dvel_y),
  .out_dvel_z     (out_dvel_z),
  .out_dpos_x     (out_dpos_x),
  .out_dpos_y     (out_dpos_y),
  .out_dpos_z     (out_dpos_z),
  .out_status     (out_status)
);

`default_nettype wire
